[design/rrct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrct_pkg
// Shared codes, widths and control bundles of the resource range claim table.
// ----------------------------------------------------------------------------
package rrct_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned TOTAL_W  = 5;

  localparam logic [KIND_W-1:0] KIND_IRQ = 2'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD     = 2'd0,
    ACT_CLAIM   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_FIND    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_OVERLAP   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BUSY      = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic finish;
  } rrct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pre_invalid;
    logic table_empty;
    logic hit;
    logic last;
    logic out_free;
  } rrct_sts_t;

endpackage

[design/rrct_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrct_req_if / rrct_rsp_if
// Valid/ready channels for requests and results of the claim table.
// ----------------------------------------------------------------------------
interface rrct_req_if;
  logic                                valid;
  logic                                ready;
  logic [rrct_pkg::ACTION_W-1:0]       action;
  logic [rrct_pkg::KIND_W-1:0]         kind;
  logic [rrct_pkg::FIELD_W-1:0]        base;
  logic [rrct_pkg::FIELD_W-1:0]        length;

  modport source (output valid, action, kind, base, length, input ready);
  modport sink   (input valid, action, kind, base, length, output ready);
endinterface

interface rrct_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [rrct_pkg::STATUS_W-1:0]       status;
  logic [rrct_pkg::SLOT_W-1:0]         slot;
  logic [rrct_pkg::FIELD_W-1:0]        slot_length;
  logic                                slot_claimed;
  logic [rrct_pkg::TOTAL_W-1:0]        claimed_total;

  modport source (output valid, status, slot, slot_length, slot_claimed, claimed_total,
                  input ready);
  modport sink   (input valid, status, slot, slot_length, slot_claimed, claimed_total,
                  output ready);
endinterface

[design/rrct_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrct_ctrl
// Sequencer: accept a request, scan the table one entry per cycle, commit.
// ----------------------------------------------------------------------------
module rrct_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrct_pkg::rrct_sts_t sts,
  output rrct_pkg::rrct_cmd_t cmd
);

  rrct_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrct_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.finish    = 1'b0;
    unique case (state_r)
      rrct_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // nothing to look at: go straight to commit
          if (sts.pre_invalid || sts.table_empty) begin
            state_nxt = rrct_pkg::S_FINISH;
          end else begin
            state_nxt = rrct_pkg::S_SCAN;
          end
        end
      end
      rrct_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit || sts.last) begin
          state_nxt = rrct_pkg::S_FINISH;
        end
      end
      rrct_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = rrct_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rrct_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[design/rrct_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrct_datapath
// Entry memory, claimed flags, compare logic and the result register.
// ----------------------------------------------------------------------------
module rrct_datapath #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [rrct_pkg::ACTION_W-1:0]       in_action,
  input  logic [rrct_pkg::KIND_W-1:0]         in_kind,
  input  logic [rrct_pkg::FIELD_W-1:0]        in_base,
  input  logic [rrct_pkg::FIELD_W-1:0]        in_length,
  input  rrct_pkg::rrct_cmd_t                 cmd,
  output rrct_pkg::rrct_sts_t                 sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rrct_pkg::STATUS_W-1:0]       out_status,
  output logic [rrct_pkg::SLOT_W-1:0]         out_slot,
  output logic [rrct_pkg::FIELD_W-1:0]        out_slot_length,
  output logic                                out_slot_claimed,
  output logic [rrct_pkg::TOTAL_W-1:0]        out_claimed_total
);

  localparam int unsigned AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // entry storage
  logic [rrct_pkg::KIND_W-1:0] mem_kind [ENTRIES];
  logic [AW-1:0]               mem_base [ENTRIES];
  logic [AW-1:0]               mem_len  [ENTRIES];
  logic [rrct_pkg::KIND_W-1:0] rd_kind_r;
  logic [AW-1:0]               rd_base_r;
  logic [AW-1:0]               rd_len_r;
  logic [IW-1:0]               rd_addr;
  logic                        wr_en;

  // request
  rrct_pkg::action_t           act_r;
  logic [rrct_pkg::KIND_W-1:0] kind_r;
  logic [AW-1:0]               base_r;
  logic [AW-1:0]               len_r;
  logic                        inv_r;

  // table state
  logic [IW-1:0]               idx_r;
  logic [CW-1:0]               used_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [ENTRIES-1:0]          claimed_r, claimed_nxt;

  // scan result
  logic                        hit_r;
  logic [IW-1:0]               hit_idx_r;
  logic [AW-1:0]               hit_len_r;

  // result register
  logic                        out_valid_r;
  rrct_pkg::status_t           res_status;
  logic [IW-1:0]               res_idx;
  logic [AW-1:0]               res_len;
  logic                        res_claimed;
  logic                        res_report;
  logic [rrct_pkg::STATUS_W-1:0] status_r;
  logic [rrct_pkg::SLOT_W-1:0]   slot_r;
  logic [rrct_pkg::FIELD_W-1:0]  slot_len_r;
  logic                          slot_claimed_r;
  logic [rrct_pkg::TOTAL_W-1:0]  total_r;

  // compare
  logic          kind_eq, base_eq, collide, hit_now;
  logic [AW:0]   req_end, ent_end;
  logic          table_full;

  // address runs one ahead so the registered read lines up with idx_r
  assign rd_addr = cmd.accept ? '0 : idx_r + IW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_kind[used_r[IW-1:0]] <= kind_r;
      mem_base[used_r[IW-1:0]] <= base_r;
      mem_len[used_r[IW-1:0]]  <= len_r;
    end
    rd_kind_r <= mem_kind[rd_addr];
    rd_base_r <= mem_base[rd_addr];
    rd_len_r  <= mem_len[rd_addr];
  end

  assign kind_eq = (rd_kind_r == kind_r);
  assign base_eq = (rd_base_r == base_r);
  assign req_end = (AW+1)'(base_r) + (AW+1)'(len_r);
  assign ent_end = (AW+1)'(rd_base_r) + (AW+1)'(rd_len_r);

  always_comb begin
    if ((rd_len_r == '0) || (len_r == '0)) begin
      collide = base_eq;
    end else begin
      collide = ((AW+1)'(rd_base_r) < req_end) && ((AW+1)'(base_r) < ent_end);
    end
    if (act_r == rrct_pkg::ACT_ADD) begin
      hit_now = kind_eq && collide;
    end else begin
      hit_now = kind_eq && base_eq;
    end
  end

  assign table_full = (used_r == CW'(ENTRIES));

  assign sts.pre_invalid = (in_action == rrct_pkg::ACT_ADD) && (in_length[AW-1:0] == '0) &&
                           (in_kind != rrct_pkg::KIND_IRQ);
  assign sts.table_empty = (used_r == '0);
  assign sts.hit         = hit_now;
  assign sts.last        = ((CW'(idx_r) + CW'(1)) == used_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  // commit decision
  always_comb begin
    res_status  = rrct_pkg::ST_OK;
    res_idx     = hit_idx_r;
    res_len     = hit_len_r;
    res_report  = 1'b1;
    wr_en       = 1'b0;
    claimed_nxt = claimed_r;
    count_nxt   = count_r;
    if (act_r == rrct_pkg::ACT_ADD) begin
      res_idx = used_r[IW-1:0];
      res_len = len_r;
      if (inv_r) begin
        res_status = rrct_pkg::ST_INVALID;
        res_report = 1'b0;
      end else if (hit_r) begin
        res_status = rrct_pkg::ST_OVERLAP;
        res_report = 1'b0;
      end else if (table_full) begin
        res_status = rrct_pkg::ST_FULL;
        res_report = 1'b0;
      end else begin
        wr_en = cmd.finish;
      end
    end else if (!hit_r) begin
      res_status = rrct_pkg::ST_NOT_FOUND;
      res_report = 1'b0;
    end else begin
      case (act_r)
        rrct_pkg::ACT_CLAIM: begin
          if ((len_r != '0) && (hit_len_r < len_r)) begin
            res_status = rrct_pkg::ST_INVALID;
          end else if (claimed_r[hit_idx_r]) begin
            res_status = rrct_pkg::ST_BUSY;
          end else begin
            claimed_nxt[hit_idx_r] = 1'b1;
            count_nxt              = count_r + CW'(1);
          end
        end
        rrct_pkg::ACT_RELEASE: begin
          if (!claimed_r[hit_idx_r]) begin
            res_status = rrct_pkg::ST_INVALID;
          end else begin
            claimed_nxt[hit_idx_r] = 1'b0;
            count_nxt              = count_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
    // a fresh entry starts unclaimed
    res_claimed = (act_r == rrct_pkg::ACT_ADD) ? 1'b0 : claimed_nxt[hit_idx_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      used_r      <= '0;
      count_r     <= '0;
      claimed_r   <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else if (cmd.scan_step) begin
        idx_r <= idx_r + IW'(1);
        if (hit_now) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        claimed_r <= claimed_nxt;
        count_r   <= count_nxt;
        if (wr_en) begin
          used_r <= used_r + CW'(1);
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r  <= rrct_pkg::action_t'(in_action);
      kind_r <= in_kind;
      base_r <= in_base[AW-1:0];
      len_r  <= in_length[AW-1:0];
      inv_r  <= sts.pre_invalid;
    end
    if (cmd.scan_step && hit_now) begin
      hit_idx_r <= idx_r;
      hit_len_r <= rd_len_r;
    end
    if (cmd.finish) begin
      status_r       <= res_status;
      slot_r         <= res_report ? rrct_pkg::SLOT_W'(res_idx) : '0;
      slot_len_r     <= res_report ? rrct_pkg::FIELD_W'(res_len) : '0;
      slot_claimed_r <= res_report && res_claimed;
      total_r        <= rrct_pkg::TOTAL_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_slot          = slot_r;
  assign out_slot_length   = slot_len_r;
  assign out_slot_claimed  = slot_claimed_r;
  assign out_claimed_total = total_r;

endmodule

[design/resource_range_claim_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resource_range_claim_table_core
// Table of resource ranges with add, claim, release and find requests.
// ----------------------------------------------------------------------------
// One request is taken at a time. A request is accepted, then scans the
// stored entries one per cycle through the single read port of the entry
// memory, stopping at the first match (claim, release, find) or the first
// overlap (add), then commits once the output register is free. An add with
// a bad length, or any request into an empty table, skips the scan. The
// result sits in an output register, so the next request may be taken while
// it waits to be read. Base and length are masked to ADDR_WIDTH bits (at most
// 32); range ends are compared one bit wider so they never wrap.
module resource_range_claim_table_core #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  rrct_req_if.sink   in_req,
  rrct_rsp_if.source out_rsp
);

  rrct_pkg::rrct_cmd_t cmd;
  rrct_pkg::rrct_sts_t sts;

  rrct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrct_datapath #(
    .ENTRIES    (ENTRIES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_action         (in_req.action),
    .in_kind           (in_req.kind),
    .in_base           (in_req.base),
    .in_length         (in_req.length),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_rsp.valid),
    .out_ready         (out_rsp.ready),
    .out_status        (out_rsp.status),
    .out_slot          (out_rsp.slot),
    .out_slot_length   (out_rsp.slot_length),
    .out_slot_claimed  (out_rsp.slot_claimed),
    .out_claimed_total (out_rsp.claimed_total)
  );

endmodule
